@@ design/tgw_pkg.sv @@
// Shared types and constants for the triggered grain window block.
package tgw_pkg;

  // Sequencer states of the shared multiplier.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAP0,
    ST_TAP1,
    ST_SCALE
  } tgw_state_t;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TABLE  = 1'b1;

  // Phase increment after reset, Q0.32.
  localparam logic [31:0] PHASE_INC_RESET = 32'd447392;

endpackage

@@ design/triggered_grain_window.sv @@
// Top level of the triggered grain window: phase sequencer, window table and shared multiplier.
//
// Usage. Input beats arrive on in_tvalid/in_tready with the item kind on in_tuser:
// a sample beat (in_tuser low) yields one result beat on out_*, a table write beat
// (in_tuser high) loads one window table entry and yields nothing. A trigger bit on a
// sample beat restarts the grain after that sample's output has been formed.
// Configuration: cfg_wr_en with cfg_wr_data sets the Q0.32 phase increment at once.
//
// Timing. A table write completes in its accept cycle. A sample taken while the grain runs
// passes through the accept cycle, which also reads the lower table entry, the TAP0 and
// TAP1 states, in which the single multiplier weights the lower and then the upper entry
// for the interpolation, and the SCALE state, in which the same multiplier scales the
// sample. A sample taken while idle skips the table reads and goes straight to SCALE. The
// result is registered, so it shows on out_tvalid the cycle after the scale step, and the
// next input beat may be accepted while it waits. If the receiver stalls, the scale step
// holds until the output register is free, and no further input is accepted meanwhile.
// Reset clears the phase, the running flag and the sequencer, and restores the default
// increment; in_tready stays low during reset. The window table is not cleared and must
// be loaded before use.
module triggered_grain_window #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_W  = ((SAMPLE_BITS + TABLE_BITS + 18 + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 17 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // Configuration write: phase increment.
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  // Input stream.
  input  logic             in_tvalid,
  output logic             in_tready,
  // From bit 0: signal_sample, trigger, table_address, table_value, zero fill.
  input  logic [IN_W-1:0]  in_tdata,
  // Bit 0: func (0 = audio sample, 1 = table write).
  input  logic             in_tuser,
  // Output stream.
  output logic             out_tvalid,
  input  logic             out_tready,
  // From bit 0: out_sample, window_level, running, zero fill.
  output logic [OUT_W-1:0] out_tdata
);
  import tgw_pkg::*;

  localparam int TBL_LEN   = 1 << TABLE_BITS;
  localparam int TBL_DEPTH = TBL_LEN + 1;
  localparam int AW        = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int PW        = AW + 17;
  localparam int TRG_BIT   = SAMPLE_BITS;
  localparam int ADR_LSB   = SAMPLE_BITS + 1;
  localparam int VAL_LSB   = SAMPLE_BITS + TABLE_BITS + 2;
  localparam int RES_W     = SAMPLE_BITS + 17;

  // Input fields.
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_trigger;
  logic [TABLE_BITS:0]           in_addr;
  logic [15:0]                   in_value;

  assign in_sample  = in_tdata[SAMPLE_BITS-1:0];
  assign in_trigger = in_tdata[TRG_BIT];
  assign in_addr    = in_tdata[ADR_LSB +: TABLE_BITS + 1];
  assign in_value   = in_tdata[VAL_LSB +: 16];

  // State.
  tgw_state_t                    state_r, state_nxt;
  logic [31:0]                   inc_r;
  logic [31:0]                   phase_r, phase_nxt;
  logic                          run_r, run_nxt;
  logic [TABLE_BITS-1:0]         idx_r;
  logic [15:0]                   mu_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [31:0]                   acc_r, acc_nxt;
  logic [15:0]                   amp_r, amp_nxt;
  logic                          run_out_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]              out_data_r;

  // Window table with one registered read port.
  logic [15:0]         window_mem [TBL_DEPTH];
  logic [15:0]         rd_data_r;
  logic [TABLE_BITS:0] rd_addr;
  logic                rd_en;
  logic                wr_en;

  // Handshake and sequencer strobes.
  logic accept;
  logic accept_sample;
  logic out_free;
  logic scale_done;

  assign accept        = in_tvalid && in_tready;
  assign accept_sample = accept && (in_tuser == FUNC_SAMPLE);
  assign out_free      = !out_valid_r || out_tready;
  assign scale_done    = (state_r == ST_SCALE) && out_free;

  // Phase accumulator: the trigger restarts from zero before the step, and a carry
  // out of the top bit ends the grain.
  logic [31:0] phase_base;
  logic [32:0] phase_sum;

  assign phase_base = in_trigger ? 32'd0 : phase_r;
  assign phase_sum  = {1'b0, phase_base} + {1'b0, inc_r};
  assign phase_nxt  = phase_sum[31:0];
  assign run_nxt    = (in_trigger || run_r) && !phase_sum[32];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_sample) begin
          state_nxt = run_r ? ST_TAP0 : ST_SCALE;
        end
      end
      ST_TAP0:  state_nxt = ST_TAP1;
      ST_TAP1:  state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and table port control. In the idle state the block
  // is ready, so a valid beat is taken at once.
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = {1'b0, idx_r};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = rst_n;
        // First tap is read straight from the current phase.
        rd_en     = rst_n && in_tvalid && (in_tuser == FUNC_SAMPLE) && run_r;
        rd_addr   = {1'b0, phase_r[31 -: TABLE_BITS]};
        wr_en     = rst_n && in_tvalid && (in_tuser == FUNC_TABLE) &&
                    (in_addr <= (TABLE_BITS + 1)'(TBL_LEN));
      end
      ST_TAP0: begin
        rd_en   = 1'b1;
        rd_addr = {1'b0, idx_r} + (TABLE_BITS + 1)'(1);
      end
      ST_TAP1, ST_SCALE: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Shared multiplier. TAP0 weights the lower tap, TAP1 the upper tap, SCALE applies
  // the interpolated level to the sample.
  logic signed [AW-1:0] mul_a;
  logic signed [16:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic [16:0]          mu_comp;

  assign mu_comp = 17'h10000 - {1'b0, mu_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_TAP0: begin
        mul_a = AW'(signed'({1'b0, mu_comp}));
        mul_b = signed'({1'b0, rd_data_r});
      end
      ST_TAP1: begin
        mul_a = AW'(signed'({2'b00, mu_r}));
        mul_b = signed'({1'b0, rd_data_r});
      end
      ST_SCALE: begin
        mul_a = AW'(sample_r);
        mul_b = signed'({1'b0, amp_r});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // Both weighted taps stay below 2^32 in sum, so 32 bits hold the accumulation.
  logic [31:0] interp_sum;

  assign interp_sum = acc_r + prod[31:0];

  always_comb begin
    acc_nxt = acc_r;
    amp_nxt = amp_r;
    if (state_r == ST_TAP0) begin
      acc_nxt = prod[31:0];
    end
    if (state_r == ST_TAP1) begin
      amp_nxt = interp_sum[31:16];
    end else if (accept_sample) begin
      // Idle grain: the level is zero and the scale step yields zero.
      amp_nxt = 16'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (scale_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inc_r       <= PHASE_INC_RESET;
      phase_r     <= 32'd0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        inc_r <= cfg_wr_data;
      end
      if (accept_sample) begin
        phase_r <= phase_nxt;
        run_r   <= run_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    amp_r <= amp_nxt;
    if (accept_sample) begin
      idx_r     <= phase_r[31 -: TABLE_BITS];
      mu_r      <= phase_r[31 - TABLE_BITS -: 16];
      sample_r  <= in_sample;
      run_out_r <= run_nxt;
    end
    if (scale_done) begin
      out_data_r <= {run_out_r, amp_r, prod[SAMPLE_BITS + 15 : 16]};
    end
  end

  // Window table.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      window_mem[in_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= window_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

`ifndef SYNTH
  // A running sample walks through both table taps before the scale step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept_sample && run_r) |=> (state_r == ST_TAP0) ##1 (state_r == ST_TAP1)
      ##1 (state_r == ST_SCALE))
    else $error("running sample skipped an interpolation step");

  // A trigger always starts a grain: the first step from zero cannot carry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept_sample && in_trigger) |=> run_r)
    else $error("trigger did not set the running flag");

  // Table writes leave the grain state alone.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == FUNC_TABLE)) |=> ($stable(phase_r) && $stable(run_r)))
    else $error("table write disturbed the grain phase");

  // A new result appears only out of the scale step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_SCALE))
    else $error("result appeared outside the scale step");
`endif

endmodule
